>>> rtl/core/rnet_pkg.sv
package rnet_pkg;

	localparam int PIX_W      = 24;
	localparam int CH_W       = 8;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int THR_W      = 8;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [PIX_W-1:0] COLOUR_WHITE = 24'hFFFFFF;
	localparam logic [PIX_W-1:0] COLOUR_BLACK = 24'h000000;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

	localparam logic [CFG_DATA_W-1:0] WIDTH_RESET     = 11'd640;
	localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET    = 11'd480;
	localparam logic [THR_W-1:0]      THRESHOLD_RESET = 8'd1;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] width;
		logic [CFG_DATA_W-1:0] height;
		logic [THR_W-1:0]      threshold;
	} cfg_t;

	// per-pixel result control worked out by the front
	typedef struct packed {
		logic emit;
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
		logic last;
	} res_ctl_t;

	// largest absolute difference over the three colour channels
	function automatic logic [CH_W-1:0] colour_diff(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		logic [CH_W-1:0] x;
		logic [CH_W-1:0] y;
		logic [CH_W-1:0] d;
		logic [CH_W-1:0] m;
		m = '0;
		for (int k = 0; k < 3; k++) begin
			x = a[k*CH_W +: CH_W];
			y = b[k*CH_W +: CH_W];
			d = (x > y) ? x - y : y - x;
			if (d > m) m = d;
		end
		return m;
	endfunction

endpackage

>>> rtl/core/rnet_front.sv
module rnet_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rnet_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_kind,
	input  logic [rnet_pkg::PIX_W-1:0]    in_pixel,
	input  logic                          q_full,
	output logic                          push,
	output logic [$clog2(MAX_WIDTH)-1:0]  push_idx,
	output logic [rnet_pkg::PIX_W-1:0]    push_pix,
	output rnet_pkg::res_ctl_t            push_ctl
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = AW + 1;
	localparam int RW = $clog2(MAX_HEIGHT + 1) + 1;
	localparam int WX = (CW > rnet_pkg::CFG_DATA_W) ? CW : rnet_pkg::CFG_DATA_W;
	localparam int HX = (RW > rnet_pkg::CFG_DATA_W) ? RW : rnet_pkg::CFG_DATA_W;

	logic [AW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [AW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;

	logic [WX-1:0] w_ext;
	logic [WX-1:0] w_x;
	logic [HX-1:0] h_ext;
	logic [HX-1:0] h_x;
	logic [CW-1:0] w;
	logic [RW-1:0] h;

	logic          flushing;
	logic          eff;
	logic          emit;
	logic [CW-1:0] in_col_inc;
	logic [CW-1:0] out_col_inc;
	logic [RW-1:0] out_row_inc;
	logic          in_wrap;
	logic          out_wrap;
	logic          last;

	// clamp the frame size to 1..max
	always_comb begin
		w_ext = WX'(cfg.width);
		h_ext = HX'(cfg.height);
		if (w_ext == '0) begin
			w_x = WX'(1);
		end else if (w_ext > WX'(MAX_WIDTH)) begin
			w_x = WX'(MAX_WIDTH);
		end else begin
			w_x = w_ext;
		end
		if (h_ext == '0) begin
			h_x = HX'(1);
		end else if (h_ext > HX'(MAX_HEIGHT)) begin
			h_x = HX'(MAX_HEIGHT);
		end else begin
			h_x = h_ext;
		end
		w = w_x[CW-1:0];
		h = h_x[RW-1:0];
	end

	always_comb begin
		in_ready    = !q_full;
		flushing    = in_row_q >= h;
		// a drain tick while pixels are still due is taken and dropped
		eff         = in_valid && in_ready && !(in_kind && !flushing);
		emit        = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
		in_col_inc  = {1'b0, in_col_q} + CW'(1);
		out_col_inc = {1'b0, out_col_q} + CW'(1);
		out_row_inc = out_row_q + RW'(1);
		in_wrap     = in_col_inc >= w;
		out_wrap    = out_col_inc >= w;
		last        = emit && (out_row_inc >= h) && out_wrap;

		push              = eff;
		push_idx          = in_col_q;
		push_pix          = flushing ? '0 : in_pixel;
		push_ctl.emit     = emit;
		push_ctl.top_ok   = out_row_q != '0;
		push_ctl.bot_ok   = out_row_inc < h;
		push_ctl.left_ok  = out_col_q != '0;
		push_ctl.right_ok = !out_wrap;
		push_ctl.last     = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (eff) begin
			if (last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= in_col_inc[AW-1:0];
				end
				if (emit) begin
					if (out_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_inc;
					end else begin
						out_col_q <= out_col_inc[AW-1:0];
					end
				end
			end
		end
	end

endmodule

>>> rtl/core/rnet_queue.sv
module rnet_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] rdata,
	output logic              empty
);

	localparam int PW = $clog2(DEPTH);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW:0]       count_q;

	assign full  = count_q == (PW+1)'(DEPTH);
	assign empty = count_q == '0;
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

>>> rtl/core/rnet_back.sv
module rnet_back #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rnet_pkg::THR_W-1:0]    threshold,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  logic [$clog2(MAX_WIDTH)-1:0]  q_idx,
	input  logic [rnet_pkg::PIX_W-1:0]    q_pix,
	input  rnet_pkg::res_ctl_t            q_ctl,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_edge,
	output logic [rnet_pkg::PIX_W-1:0]    out_colour,
	output logic                          out_last
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int PW = rnet_pkg::PIX_W;
	localparam int DW = rnet_pkg::CH_W;

	logic [PW-1:0] near_mem [MAX_WIDTH];
	logic [PW-1:0] far_mem  [MAX_WIDTH];

	logic               en;
	logic               far_we;

	// s2: line store read data
	logic               s2_valid_q;
	logic [AW-1:0]      idx_s2;
	logic [PW-1:0]      pix_s2;
	rnet_pkg::res_ctl_t ctl_s2;
	logic [PW-1:0]      near_rd_s2;
	logic [PW-1:0]      far_rd_s2;
	logic               fwd_s2;
	logic [PW-1:0]      fwd_top_s2;
	logic [PW-1:0]      top_s2;

	// s3: window holds the item, neighbour differences formed
	logic [PW-1:0]      win_q [3][3];
	logic               s3_valid_q;
	rnet_pkg::res_ctl_t ctl_s3;
	logic [DW-1:0]      diff [3][3];
	logic               row_ok [3];
	logic               col_ok [3];

	// s4: differences reduced and compared
	logic               s4_valid_q;
	logic               last_s4;
	logic [DW-1:0]      diff_s4 [3][3];
	logic [DW-1:0]      maxd;

	logic               out_valid_q;
	logic               out_edge_q;
	logic               out_last_q;

	assign en     = !out_valid_q || out_ready;
	assign q_pop  = en && !q_empty;
	assign far_we = en && s2_valid_q;

	// near store written at read time, far store as s2 advances, with the old near value
	always_ff @(posedge clk) begin
		if (q_pop) begin
			near_rd_s2      <= near_mem[q_idx];
			far_rd_s2       <= far_mem[q_idx];
			near_mem[q_idx] <= q_pix;
		end
		if (far_we) begin
			far_mem[idx_s2] <= near_rd_s2;
		end
	end

	// the far write of the item in s2 lands in the same cycle as this read
	always_ff @(posedge clk) begin
		if (q_pop) begin
			idx_s2     <= q_idx;
			pix_s2     <= q_pix;
			ctl_s2     <= q_ctl;
			fwd_s2     <= s2_valid_q && (idx_s2 == q_idx);
			fwd_top_s2 <= near_rd_s2;
		end
	end

	assign top_s2 = fwd_s2 ? fwd_top_s2 : far_rd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (far_we) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= top_s2;
			win_q[1][2] <= near_rd_s2;
			win_q[2][2] <= pix_s2;
		end
	end

	always_comb begin
		row_ok[0] = ctl_s3.top_ok;
		row_ok[1] = 1'b1;
		row_ok[2] = ctl_s3.bot_ok;
		col_ok[0] = ctl_s3.left_ok;
		col_ok[1] = 1'b1;
		col_ok[2] = ctl_s3.right_ok;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				diff[r][c] = (row_ok[r] && col_ok[c]) ?
					rnet_pkg::colour_diff(win_q[1][1], win_q[r][c]) : '0;
			end
		end
	end

	always_comb begin
		maxd = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (diff_s4[r][c] > maxd) maxd = diff_s4[r][c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (far_we) begin
			ctl_s3 <= ctl_s2;
		end
		if (en) begin
			last_s4    <= ctl_s3.last;
			diff_s4    <= diff;
			out_edge_q <= maxd > threshold;
			out_last_q <= last_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q  <= 1'b0;
			s3_valid_q  <= 1'b0;
			s4_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			s2_valid_q  <= q_pop;
			s3_valid_q  <= s2_valid_q && ctl_s2.emit;
			s4_valid_q  <= s3_valid_q;
			out_valid_q <= s4_valid_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_edge   = out_edge_q;
	assign out_last   = out_last_q;
	assign out_colour = out_edge_q ? rnet_pkg::COLOUR_BLACK : rnet_pkg::COLOUR_WHITE;

endmodule

>>> rtl/core/rgb_neighbour_edge_threshold_top.sv
// 3x3 edge detector for a raster stream of 24-bit rgb pixels. A pixel is marked as an edge
// (black, tuser high) when the largest per-channel difference to any in-frame neighbour exceeds
// edge_threshold, else it comes out white. One item is taken every clock while the queue is not
// full: the front classifies each item combinationally and the back reads and writes each line
// store once per item in a pipeline, so one pixel per clock is kept up while the output is not
// stalled. Results lag the input by one line plus one pixel of the stream; after the frame's last
// pixel, send width + 1 drain items (tuser high) to flush the last row, and tlast marks the
// frame's final result. Drain items sent while pixels are still due are taken and dropped. A
// result's item passes the queue and stages s2, s3 and s4 before tvalid rises. The line stores
// start unwritten and need no clearing pass. Configuration writes are taken at any time but
// belong between frames or while the block is idle.
module rgb_neighbour_edge_threshold_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [rnet_pkg::PIX_W-1:0]            s_axis_tdata,  // pixel_rgb
	input  logic                                  s_axis_tuser,  // kind
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [rnet_pkg::PIX_W-1:0]            m_axis_tdata,  // out_colour
	output logic                                  m_axis_tuser,  // is_edge
	output logic                                  m_axis_tlast,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rnet_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rnet_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CTL_W = $bits(rnet_pkg::res_ctl_t);
	localparam int QW = AW + rnet_pkg::PIX_W + CTL_W;

	rnet_pkg::cfg_t             cfg_q;
	logic                       q_push;
	logic                       q_pop;
	logic                       q_full;
	logic                       q_empty;
	logic [AW-1:0]              push_idx;
	logic [rnet_pkg::PIX_W-1:0] push_pix;
	rnet_pkg::res_ctl_t         push_ctl;
	logic [QW-1:0]              q_rdata;
	logic [AW-1:0]              pop_idx;
	logic [rnet_pkg::PIX_W-1:0] pop_pix;
	rnet_pkg::res_ctl_t         pop_ctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width     <= rnet_pkg::WIDTH_RESET;
			cfg_q.height    <= rnet_pkg::HEIGHT_RESET;
			cfg_q.threshold <= rnet_pkg::THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rnet_pkg::CFG_IMAGE_WIDTH: begin
					cfg_q.width <= cfg_data;
				end
				rnet_pkg::CFG_IMAGE_HEIGHT: begin
					cfg_q.height <= cfg_data;
				end
				rnet_pkg::CFG_EDGE_THRESHOLD: begin
					cfg_q.threshold <= cfg_data[rnet_pkg::THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	rnet_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (s_axis_tuser),
		.in_pixel (s_axis_tdata),
		.q_full   (q_full),
		.push     (q_push),
		.push_idx (push_idx),
		.push_pix (push_pix),
		.push_ctl (push_ctl)
	);

	rnet_queue #(
		.DATA_W (QW),
		.DEPTH  (rnet_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({push_idx, push_pix, push_ctl}),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign {pop_idx, pop_pix, pop_ctl} = q_rdata;

	rnet_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.threshold  (cfg_q.threshold),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.q_idx      (pop_idx),
		.q_pix      (pop_pix),
		.q_ctl      (pop_ctl),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_edge   (m_axis_tuser),
		.out_colour (m_axis_tdata),
		.out_last   (m_axis_tlast)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata == rnet_pkg::COLOUR_BLACK)))
		else $error("edge flag and colour disagree");

	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("item pushed into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("item popped from an empty queue");

endmodule

>>> sim/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_MAX_W   = 1024;
	localparam int FRAME_MAX_H   = 1024;
	localparam int SETTLE_CYCLES = 12;
	localparam int RAND_ITEMS    = 1020;
	localparam int DIR_ROWS      = 25;
	localparam longint TIMEOUT_NS = 3_000_000;

	typedef enum logic {KIND_PIXEL = 1'b0, KIND_DRAIN = 1'b1} kind_e;
	typedef enum logic {ROW_ITEM = 1'b0, ROW_CFG = 1'b1} row_op_e;

	typedef struct packed {
		logic                       is_edge;
		logic [rnet_pkg::PIX_W-1:0] colour;
		logic                       last;
	} px_result_t;

	typedef struct packed {
		row_op_e                         op;
		logic [rnet_pkg::CFG_IDX_W-1:0]  idx;
		logic [rnet_pkg::CFG_DATA_W-1:0] val;
		kind_e                           kind;
		logic [rnet_pkg::PIX_W-1:0]      pix;
		logic                            chk;
		logic                            want_edge;
		logic                            want_last;
	} stim_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [rnet_pkg::PIX_W-1:0]      s_axis_tdata;   // pixel_rgb
	logic                            s_axis_tuser;   // kind
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [rnet_pkg::PIX_W-1:0]      m_axis_tdata;   // out_colour
	logic                            m_axis_tuser;   // is_edge
	logic                            m_axis_tlast;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [rnet_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [rnet_pkg::CFG_DATA_W-1:0] cfg_data;

	// typed expectation that travels alongside the offered item
	logic tab_chk;
	logic tab_edge;
	logic tab_last;

	// edge predictor state
	logic [rnet_pkg::PIX_W-1:0]      near_row [FRAME_MAX_W];
	logic [rnet_pkg::PIX_W-1:0]      far_row [FRAME_MAX_W];
	logic [rnet_pkg::PIX_W-1:0]      win [3][3];
	int unsigned                     in_col, in_row, out_col, out_row;
	logic [rnet_pkg::CFG_DATA_W-1:0] pr_width;
	logic [rnet_pkg::CFG_DATA_W-1:0] pr_height;
	logic [rnet_pkg::THR_W-1:0]      pr_thr;

	px_result_t  due_px[$];
	int unsigned fail_count = 0;
	bit          src_calm = 1'b0;

	stim_row_t dir_tab [0:DIR_ROWS-1] = '{
		// 2x2, threshold 255: full-scale steps do not exceed it
		'{ROW_CFG, rnet_pkg::CFG_IMAGE_WIDTH, 11'd2, KIND_PIXEL, 24'h000000, 1'b0, 1'b0, 1'b0},
		'{ROW_CFG, rnet_pkg::CFG_IMAGE_HEIGHT, 11'd2, KIND_PIXEL, 24'h000000, 1'b0, 1'b0, 1'b0},
		'{ROW_CFG, rnet_pkg::CFG_EDGE_THRESHOLD, 11'd255, KIND_PIXEL, 24'h000000,
			1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_PIXEL, 24'h000000, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_PIXEL, 24'hFFFFFF, 1'b0, 1'b0, 1'b0},
		// drain while pixels are still due is dropped
		'{ROW_ITEM, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_DRAIN, 24'hA5A5A5, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_PIXEL, 24'hFFFFFF, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_PIXEL, 24'h000000, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_DRAIN, 24'h000000, 1'b1, 1'b0, 1'b0},
		// pixel during the flush counts as a drain
		'{ROW_ITEM, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_PIXEL, 24'h123456, 1'b1, 1'b0, 1'b0},
		'{ROW_ITEM, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_DRAIN, 24'h000000, 1'b1, 1'b0, 1'b1},
		// threshold 0: a one-lsb step in blue marks every pixel
		'{ROW_CFG, rnet_pkg::CFG_EDGE_THRESHOLD, 11'd0, KIND_PIXEL, 24'h000000,
			1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_PIXEL, 24'h010000, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_PIXEL, 24'h010000, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_PIXEL, 24'h010000, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_PIXEL, 24'h010001, 1'b1, 1'b1, 1'b0},
		'{ROW_ITEM, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_DRAIN, 24'h000000, 1'b1, 1'b1, 1'b0},
		'{ROW_ITEM, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_DRAIN, 24'h000000, 1'b1, 1'b1, 1'b0},
		'{ROW_ITEM, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_DRAIN, 24'h000000, 1'b1, 1'b1, 1'b1},
		// zero sizes act as 1x1: a lone pixel has no neighbours
		'{ROW_CFG, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_PIXEL, 24'h000000, 1'b0, 1'b0, 1'b0},
		'{ROW_CFG, rnet_pkg::CFG_IMAGE_HEIGHT, 11'd0, KIND_PIXEL, 24'h000000, 1'b0, 1'b0, 1'b0},
		'{ROW_CFG, rnet_pkg::CFG_EDGE_THRESHOLD, 11'd1, KIND_PIXEL, 24'h000000,
			1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_PIXEL, 24'hFFFFFF, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_DRAIN, 24'h000000, 1'b0, 1'b0, 1'b0},
		'{ROW_ITEM, rnet_pkg::CFG_IMAGE_WIDTH, 11'd0, KIND_DRAIN, 24'h000000, 1'b1, 1'b0, 1'b1}
	};

	rgb_neighbour_edge_threshold_top #(
		.MAX_WIDTH (FRAME_MAX_W),
		.MAX_HEIGHT(FRAME_MAX_H)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned eff_dim(input logic [rnet_pkg::CFG_DATA_W-1:0] v,
			input int unsigned hi);
		if (v == '0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int unsigned max_chan_gap(input logic [rnet_pkg::PIX_W-1:0] a,
			input logic [rnet_pkg::PIX_W-1:0] b);
		int unsigned m, x, y, d;
		m = 0;
		for (int k = 0; k < 3; k++) begin
			x = a[rnet_pkg::CH_W*k +: rnet_pkg::CH_W];
			y = b[rnet_pkg::CH_W*k +: rnet_pkg::CH_W];
			d = (x > y) ? x - y : y - x;
			if (d > m) m = d;
		end
		return m;
	endfunction

	function automatic int unsigned pause_len(input bit calm);
		int unsigned r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic void clear_model();
		for (int i = 0; i < FRAME_MAX_W; i++) begin
			near_row[i] = '0;
			far_row[i] = '0;
		end
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				win[r][c] = '0;
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
		pr_width = rnet_pkg::WIDTH_RESET;
		pr_height = rnet_pkg::HEIGHT_RESET;
		pr_thr = rnet_pkg::THRESHOLD_RESET;
	endfunction

	// advances the window by one accepted item; returns 1 when a pixel result falls out
	function automatic bit classify_step(input logic kind,
			input logic [rnet_pkg::PIX_W-1:0] pix_in, output px_result_t res);
		int unsigned w, h, col_i, worst, gap;
		logic [rnet_pkg::PIX_W-1:0] pix, upper, middle, centre;
		bit flushing, emit;
		w = eff_dim(pr_width, FRAME_MAX_W);
		h = eff_dim(pr_height, FRAME_MAX_H);
		res = '0;
		flushing = (in_row >= h);
		if (kind == KIND_DRAIN && !flushing) return 1'b0;
		pix = flushing ? '0 : pix_in;

		col_i = in_col % FRAME_MAX_W;
		upper = far_row[col_i];
		middle = near_row[col_i];
		far_row[col_i] = middle;
		near_row[col_i] = pix;
		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = upper;
		win[1][2] = middle;
		win[2][2] = pix;

		emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (!emit) return 1'b0;

		centre = win[1][1];
		worst = 0;
		for (int r = 0; r < 3; r++) begin
			if (r == 0 && out_row == 0) continue;
			if (r == 2 && out_row + 1 >= h) continue;
			for (int c = 0; c < 3; c++) begin
				if (c == 0 && out_col == 0) continue;
				if (c == 2 && out_col + 1 >= w) continue;
				gap = max_chan_gap(centre, win[r][c]);
				if (gap > worst) worst = gap;
			end
		end
		res.is_edge = (worst > pr_thr);
		res.colour = res.is_edge ? rnet_pkg::COLOUR_BLACK : rnet_pkg::COLOUR_WHITE;
		res.last = (out_row + 1 >= h) && (out_col + 1 >= w);

		if (res.last) begin
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
		return 1'b1;
	endfunction

	// results are checked before the same edge's input item is predicted
	always @(posedge clk) begin : scoreboard
		px_result_t want, got, typed;
		bit emitted;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tuser, m_axis_tdata, m_axis_tlast};
				if (due_px.size() == 0) begin
					$display("%0t: result with none expected: is_edge %0b colour %06h last %0b",
						$time, got.is_edge, got.colour, got.last);
					fail_count++;
				end else begin
					want = due_px.pop_front();
					if (got.is_edge !== want.is_edge) begin
						$display("%0t: is_edge mismatch: expected %0b, actual %0b",
							$time, want.is_edge, got.is_edge);
						fail_count++;
					end
					if (got.colour !== want.colour) begin
						$display("%0t: colour mismatch: expected %06h, actual %06h",
							$time, want.colour, got.colour);
						fail_count++;
					end
					if (got.last !== want.last) begin
						$display("%0t: tlast mismatch: expected %0b, actual %0b",
							$time, want.last, got.last);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				emitted = classify_step(s_axis_tuser, s_axis_tdata, want);
				if (tab_chk) begin
					typed.is_edge = tab_edge;
					typed.colour = tab_edge ? rnet_pkg::COLOUR_BLACK : rnet_pkg::COLOUR_WHITE;
					typed.last = tab_last;
					due_px = {due_px, typed};
				end else if (emitted) begin
					due_px = {due_px, want};
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rnet_pkg::CFG_IMAGE_WIDTH: pr_width = cfg_data;
					rnet_pkg::CFG_IMAGE_HEIGHT: pr_height = cfg_data;
					rnet_pkg::CFG_EDGE_THRESHOLD: pr_thr = cfg_data[rnet_pkg::THR_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// output side: short random stalls, calm windows, and one long hold-off
	initial begin : result_sink
		int unsigned wait_left, taken, window;
		bit calm, held;
		wait_left = 0;
		taken = 0;
		window = 0;
		calm = 1'b0;
		held = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (m_axis_tvalid && m_axis_tready) taken++;
				if (window == 0) begin
					calm = ($urandom_range(0, 3) == 0);
					window = 64;
				end else begin
					window--;
				end
				// block fills up and must push back on its input
				if (!held && taken >= 300) begin
					held = 1'b1;
					wait_left = 400;
				end
				if (wait_left > 0) begin
					wait_left--;
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
					wait_left = pause_len(calm);
				end
			end
		end
	end

	task automatic push_item(input kind_e kind, input logic [rnet_pkg::PIX_W-1:0] pix,
			input logic chk, input logic want_edge, input logic want_last);
		int unsigned idle;
		idle = pause_len(src_calm);
		if (idle != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= pix;
		tab_chk <= chk;
		tab_edge <= want_edge;
		tab_last <= want_last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_reg(input logic [rnet_pkg::CFG_IDX_W-1:0] idx,
			input logic [rnet_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every due result, then let the pipeline run dry
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		// the item taken at the edge just passed may not be predicted yet
		@(posedge clk);
		while (due_px.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_frame(input int unsigned w, input int unsigned h,
			input logic [rnet_pkg::PIX_W-1:0] mask, output int unsigned used);
		logic [rnet_pkg::PIX_W-1:0] base;
		int unsigned extra;
		base = $urandom;
		extra = 0;
		for (int unsigned n = 0; n < w * h; n++) begin
			if ($urandom_range(0, 99) < 8) begin
				push_item(KIND_DRAIN, $urandom, 1'b0, 1'b0, 1'b0);
				extra++;
			end
			push_item(KIND_PIXEL, base ^ ($urandom & mask), 1'b0, 1'b0, 1'b0);
		end
		for (int unsigned n = 0; n <= w; n++) begin
			if ($urandom_range(0, 99) < 25)
				push_item(KIND_PIXEL, $urandom, 1'b0, 1'b0, 1'b0);
			else
				push_item(KIND_DRAIN, $urandom, 1'b0, 1'b0, 1'b0);
		end
		used = w * h + w + 1 + extra;
	endtask

	initial begin : stimulus
		int unsigned rand_items, frames, used;
		logic [rnet_pkg::CFG_DATA_W-1:0] w_val, h_val;
		logic [rnet_pkg::THR_W-1:0] thr, m;
		clear_model();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tab_chk = 1'b0;
		tab_edge = 1'b0;
		tab_last = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].op == ROW_CFG) begin
				settle();
				write_reg(dir_tab[i].idx, dir_tab[i].val);
			end else begin
				push_item(dir_tab[i].kind, dir_tab[i].pix, dir_tab[i].chk,
					dir_tab[i].want_edge, dir_tab[i].want_last);
			end
		end

		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			w_val = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			h_val = $urandom_range(1, 6);
			case ($urandom_range(0, 4))
				0: m = 8'h00;
				1: m = 8'h01;
				2: m = 8'h07;
				3: m = 8'h1F;
				default: m = 8'hFF;
			endcase
			thr = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 255) : $urandom_range(0, m);
			settle();
			write_reg(rnet_pkg::CFG_IMAGE_WIDTH, w_val);
			write_reg(rnet_pkg::CFG_IMAGE_HEIGHT, h_val);
			// upper data bits are not part of the threshold
			write_reg(rnet_pkg::CFG_EDGE_THRESHOLD,
				{(($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'b000), thr});
			src_calm = ($urandom_range(0, 3) == 0);
			frames = $urandom_range(1, 3);
			repeat (frames) begin
				run_frame(eff_dim(w_val, FRAME_MAX_W), eff_dim(h_val, FRAME_MAX_H),
					{m, m, m}, used);
				rand_items += used;
			end
		end

		settle();
		if (fail_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/rnet_pkg.sv
rtl/core/rnet_front.sv
rtl/core/rnet_queue.sv
rtl/core/rnet_back.sv
rtl/core/rgb_neighbour_edge_threshold_top.sv
sim/tb_top.sv
